// ===== rtl/crm_pkg.sv =====
// Package with the shared types, constants and the byte-mask helper function of the CAN reassembler.
package crm_pkg;

	localparam int NUM_SLOTS_DEF  = 6;
	localparam int MAX_CHUNKS_DEF = 4;
	localparam int SEQ_BITS_DEF   = 2;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 64;
	localparam int CFG_W       = 36;
	localparam int FIELD_W     = 6;
	localparam int FIELD_SPAN  = 48;
	localparam int ORIGIN_W    = 5;
	localparam int NCH_W       = 3;
	localparam int BYTES       = 8;

	localparam logic [4:0] ORIGIN_A_RST = 5'd0;
	localparam logic [4:0] ORIGIN_B_RST = 5'd1;

	typedef enum logic [1:0] {
		REG_ORIGIN_A = 2'd0,
		REG_ORIGIN_B = 2'd1,
		REG_BASE_IDS = 2'd2,
		REG_SIZES    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		K_DROP   = 2'd0,
		K_SINGLE = 2'd1,
		K_STORE  = 2'd2,
		K_START  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [4:0]       origin_a;
		logic [4:0]       origin_b;
		logic [CFG_W-1:0] base_ids;
		logic [CFG_W-1:0] sizes;
	} cfg_t;

	typedef struct packed {
		logic              status;
		logic [5:0]        message_id;
		logic [4:0]        message_origin;
		logic [DATA_W-1:0] chunk_data;
		logic [3:0]        chunk_bytes;
		logic [5:0]        message_bytes;
		logic              last_chunk;
	} result_t;

	typedef struct packed {
		logic [5:0]       id;
		logic [4:0]       origin;
		logic [5:0]       size;
		logic [NCH_W-1:0] nchunks;
	} emit_cmd_t;

	function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < BYTES; i++) begin
			m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

// ===== rtl/crm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module crm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/crm_cfg.sv =====
// Configuration register file behind the APB-style port.
module crm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crm_pkg::ADDR_W-1:0]  paddr,
	input  logic [crm_pkg::DATA_W-1:0]  pwdata,
	output logic [crm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output crm_pkg::cfg_t               cfg
);

	crm_pkg::cfg_t     cfg_q;
	crm_pkg::cfg_reg_t reg_sel;
	logic              wr;

	assign reg_sel = crm_pkg::cfg_reg_t'(paddr[4:3]);
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_a <= crm_pkg::ORIGIN_A_RST;
			cfg_q.origin_b <= crm_pkg::ORIGIN_B_RST;
			cfg_q.base_ids <= '0;
			cfg_q.sizes    <= '0;
		end else if (wr) begin
			case (reg_sel)
				crm_pkg::REG_ORIGIN_A: cfg_q.origin_a <= pwdata[4:0];
				crm_pkg::REG_ORIGIN_B: cfg_q.origin_b <= pwdata[4:0];
				crm_pkg::REG_BASE_IDS: cfg_q.base_ids <= pwdata[crm_pkg::CFG_W-1:0];
				crm_pkg::REG_SIZES:    cfg_q.sizes    <= pwdata[crm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			crm_pkg::REG_ORIGIN_A: prdata = crm_pkg::DATA_W'(cfg_q.origin_a);
			crm_pkg::REG_ORIGIN_B: prdata = crm_pkg::DATA_W'(cfg_q.origin_b);
			crm_pkg::REG_BASE_IDS: prdata = crm_pkg::DATA_W'(cfg_q.base_ids);
			crm_pkg::REG_SIZES:    prdata = crm_pkg::DATA_W'(cfg_q.sizes);
			default:               prdata = '0;
		endcase
	end

endmodule

// ===== rtl/crm_ctrl.sv =====
// Frame input register, slot match, slot state, result-kind decision and store-write decision.
module crm_ctrl #(
	parameter int NUM_SLOTS  = crm_pkg::NUM_SLOTS_DEF,
	parameter int MAX_CHUNKS = crm_pkg::MAX_CHUNKS_DEF,
	parameter int SEQ_BITS   = crm_pkg::SEQ_BITS_DEF,
	localparam int DEPTH = NUM_SLOTS * MAX_CHUNKS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  crm_pkg::cfg_t                      cfg,
	input  logic                               frame_valid,
	output logic                               frame_stall,
	input  logic [10:0]                        frame_id,
	input  logic [crm_pkg::DATA_W-1:0]         frame_data,
	input  logic [3:0]                         frame_length,
	input  logic                               em_busy,
	input  logic                               out_free,
	output logic                               single_ld,
	output crm_pkg::result_t                   single_res,
	output logic                               start,
	output crm_pkg::emit_cmd_t                 start_cmd,
	output logic [SW-1:0]                      start_slot,
	output logic [crm_pkg::BYTES-1:0]          ram_be,
	output logic [AW-1:0]                      ram_waddr,
	output logic [crm_pkg::DATA_W-1:0]         ram_wdata
);

	localparam int SEQ_MASK = (1 << SEQ_BITS) - 1;
	localparam int CAP = ((MAX_CHUNKS < (1 << SEQ_BITS)) ? MAX_CHUNKS : (1 << SEQ_BITS)) * 8;

	logic                      valid_s1;
	logic [10:0]               id_s1;
	logic [crm_pkg::DATA_W-1:0] data_s1;
	logic [3:0]                len_s1;

	logic [MAX_CHUNKS-1:0]     valid_q [NUM_SLOTS];
	logic                      locked_q [NUM_SLOTS];
	logic [crm_pkg::ORIGIN_W-1:0] lock_org_q [NUM_SLOTS];

	logic [5:0]                msg_id;
	logic [4:0]                org;
	logic [5:0]                masked_id;
	logic [SEQ_BITS-1:0]       seq;
	logic                      org_ok;
	logic                      found;
	logic [SW-1:0]             slot;
	logic [crm_pkg::FIELD_SPAN-1:0] ids_ext;
	logic [crm_pkg::FIELD_SPAN-1:0] sizes_ext;
	logic [5:0]                base_id;
	logic [5:0]                size_raw;
	logic [5:0]                size_eff;
	logic                      conflict;
	logic                      chk_ok;
	logic                      store_en;
	logic [MAX_CHUNKS-1:0]     seq_bit;
	logic [MAX_CHUNKS-1:0]     need;
	logic [MAX_CHUNKS-1:0]     valid_new;
	logic [crm_pkg::NCH_W-1:0] nch;
	logic                      complete;
	crm_pkg::kind_t            kind;
	logic                      go;

	assign msg_id    = id_s1[10:5];
	assign org       = id_s1[4:0];
	assign masked_id = msg_id & ~6'(SEQ_MASK);
	assign seq       = id_s1[5 +: SEQ_BITS];
	assign ids_ext   = crm_pkg::FIELD_SPAN'(cfg.base_ids);
	assign sizes_ext = crm_pkg::FIELD_SPAN'(cfg.sizes);

	always_comb begin
		found = 1'b0;
		slot  = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!found && masked_id == ids_ext[crm_pkg::FIELD_W*k +: crm_pkg::FIELD_W]) begin
				found = 1'b1;
				slot  = SW'(k);
			end
		end
	end

	always_comb begin
		org_ok    = (org == cfg.origin_a) || (org == cfg.origin_b);
		base_id   = ids_ext[crm_pkg::FIELD_W*32'(slot) +: crm_pkg::FIELD_W];
		size_raw  = sizes_ext[crm_pkg::FIELD_W*32'(slot) +: crm_pkg::FIELD_W];
		size_eff  = (size_raw > 6'(CAP)) ? 6'(CAP) : size_raw;
		conflict  = locked_q[slot] && (lock_org_q[slot] != org);
		chk_ok    = (len_s1 <= 4'd8) &&
		            (7'({seq, 3'b000}) + 7'(len_s1) <= 7'(size_eff));
		store_en  = 3'(seq) < 3'(MAX_CHUNKS);
		nch       = crm_pkg::NCH_W'((7'(size_eff) + 7'd7) >> 3);
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			seq_bit[i] = store_en && (32'(seq) == i);
			need[i]    = 3'(i) < nch;
		end
		valid_new = valid_q[slot] | seq_bit;
		complete  = chk_ok && ((valid_new & need) == need);

		if (!org_ok) begin
			kind = crm_pkg::K_DROP;
		end else if (!found || conflict || !chk_ok) begin
			kind = crm_pkg::K_SINGLE;
		end else if (complete && nch == '0) begin
			kind = crm_pkg::K_SINGLE;
		end else if (complete) begin
			kind = crm_pkg::K_START;
		end else begin
			kind = crm_pkg::K_STORE;
		end

		go = valid_s1 && !em_busy && (kind != crm_pkg::K_SINGLE || out_free);
	end

	always_comb begin
		single_res.message_id     = msg_id;
		single_res.message_origin = org;
		single_res.last_chunk     = 1'b1;
		if (org_ok && found && !conflict && chk_ok) begin
			single_res.status        = 1'b0;
			single_res.message_id    = base_id;
			single_res.chunk_data    = '0;
			single_res.chunk_bytes   = '0;
			single_res.message_bytes = '0;
		end else if (!found && len_s1 <= 4'd8) begin
			single_res.status        = 1'b0;
			single_res.chunk_data    = data_s1 & crm_pkg::byte_mask(len_s1);
			single_res.chunk_bytes   = len_s1;
			single_res.message_bytes = 6'(len_s1);
		end else begin
			single_res.status        = 1'b1;
			single_res.chunk_data    = '0;
			single_res.chunk_bytes   = '0;
			single_res.message_bytes = '0;
		end
	end

	assign single_ld         = go && (kind == crm_pkg::K_SINGLE);
	assign start             = go && (kind == crm_pkg::K_START);
	assign start_cmd.id      = base_id;
	assign start_cmd.origin  = org;
	assign start_cmd.size    = size_eff;
	assign start_cmd.nchunks = nch;
	assign start_slot        = slot;
	assign frame_stall       = valid_s1 && !go;
	assign ram_waddr         = AW'(32'(slot) * MAX_CHUNKS + 32'(seq));
	assign ram_wdata         = data_s1;

	always_comb begin
		for (int b = 0; b < crm_pkg::BYTES; b++) begin
			ram_be[b] = go && (kind == crm_pkg::K_STORE || kind == crm_pkg::K_START) &&
			            store_en && (4'(b) < len_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_valid && !frame_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			id_s1   <= frame_id;
			data_s1 <= frame_data;
			len_s1  <= frame_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				valid_q[k]    <= '0;
				locked_q[k]   <= 1'b0;
				lock_org_q[k] <= '0;
			end
		end else if (go && org_ok && found && !conflict) begin
			if (complete) begin
				valid_q[slot]    <= '0;
				locked_q[slot]   <= 1'b0;
				lock_org_q[slot] <= '0;
			end else begin
				locked_q[slot]   <= 1'b1;
				lock_org_q[slot] <= org;
				if (chk_ok) begin
					valid_q[slot] <= valid_new;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> em_busy)
		else $error("Readout did not start after a completing frame.");
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		em_busy |-> !go)
		else $error("Frame retired while a message was being read out.");
`endif

endmodule

// ===== rtl/crm_emit.sv =====
// Message readout sequencer and the result register.
module crm_emit #(
	parameter int NUM_SLOTS  = crm_pkg::NUM_SLOTS_DEF,
	parameter int MAX_CHUNKS = crm_pkg::MAX_CHUNKS_DEF,
	localparam int DEPTH = NUM_SLOTS * MAX_CHUNKS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       single_ld,
	input  crm_pkg::result_t           single_res,
	input  logic                       start,
	input  crm_pkg::emit_cmd_t         start_cmd,
	input  logic [SW-1:0]              start_slot,
	output logic                       ram_re,
	output logic [AW-1:0]              ram_raddr,
	input  logic [crm_pkg::DATA_W-1:0] ram_rdata,
	output logic                       busy,
	output logic                       out_free,
	output logic                       result_valid,
	input  logic                       result_stall,
	output crm_pkg::result_t           result
);

	logic                      busy_q;
	logic                      pend_q;
	logic [crm_pkg::NCH_W-1:0] next_q;
	logic [crm_pkg::NCH_W-1:0] pidx_q;
	crm_pkg::emit_cmd_t        cmd_q;
	logic [SW-1:0]             slot_q;
	logic                      valid_q;
	crm_pkg::result_t          res_q;

	logic                      ld_ram;
	logic                      last_word;
	logic [5:0]                rem;
	logic [3:0]                cb;
	crm_pkg::result_t          ram_res;

	assign out_free     = !valid_q || !result_stall;
	assign ld_ram       = pend_q && out_free;
	assign ram_re       = busy_q && (next_q < cmd_q.nchunks) && (!pend_q || ld_ram);
	assign ram_raddr    = AW'(32'(slot_q) * MAX_CHUNKS + 32'(next_q));
	assign last_word    = pidx_q == (cmd_q.nchunks - 3'd1);
	assign rem          = cmd_q.size - {pidx_q, 3'b000};
	assign cb           = (rem > 6'd8) ? 4'd8 : 4'(rem);
	assign busy         = busy_q;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_comb begin
		ram_res.status         = 1'b0;
		ram_res.message_id     = cmd_q.id;
		ram_res.message_origin = cmd_q.origin;
		ram_res.chunk_data     = ram_rdata & crm_pkg::byte_mask(cb);
		ram_res.chunk_bytes    = cb;
		ram_res.message_bytes  = cmd_q.size;
		ram_res.last_chunk     = last_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			next_q <= '0;
			pidx_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				next_q <= '0;
			end else if (ld_ram && last_word) begin
				busy_q <= 1'b0;
			end
			if (ram_re) begin
				pend_q <= 1'b1;
				pidx_q <= next_q;
				next_q <= next_q + 3'd1;
			end else if (ld_ram) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q  <= start_cmd;
			slot_q <= start_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (single_ld || ld_ram) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (single_ld) begin
			res_q <= single_res;
		end else if (ld_ram) begin
			res_q <= ram_res;
		end
	end

`ifndef ASSERT_OFF
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> busy_q)
		else $error("Read pending with no message in readout.");
	a_single_idle: assert property (@(posedge clk) disable iff (!arst_n)
		single_ld |-> (!busy_q && out_free))
		else $error("Single result loaded during readout or into a full register.");
	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (next_q <= cmd_q.nchunks))
		else $error("Readout index ran past the message length.");
`endif

endmodule

// ===== rtl/can_multipacket_reassembler.sv =====
// Top level of the CAN multi-frame message reassembler.
// Path: a single-frame or error result passes the frame input register and the result register;
// a reassembled message passes the frame input register, readout state, store read and result register.
// Throughput: one frame per cycle unless stalled; a completing frame holds the input for the
// readout: one result beat per cycle unless stalled, from the store's single read port.
// Reset clears control, slot locks and chunk valid marks and restores the registers;
// the chunk store is not cleared.
module can_multipacket_reassembler #(
	parameter int NUM_SLOTS  = crm_pkg::NUM_SLOTS_DEF,
	parameter int MAX_CHUNKS = crm_pkg::MAX_CHUNKS_DEF,
	parameter int SEQ_BITS   = crm_pkg::SEQ_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [crm_pkg::ADDR_W-1:0] paddr,
	input  logic [crm_pkg::DATA_W-1:0] pwdata,
	output logic [crm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       frame_valid,
	output logic                       frame_stall,
	input  logic [10:0]                frame_id,
	input  logic [63:0]                frame_data,
	input  logic [3:0]                 frame_length,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       status,
	output logic [5:0]                 message_id,
	output logic [4:0]                 message_origin,
	output logic [63:0]                chunk_data,
	output logic [3:0]                 chunk_bytes,
	output logic [5:0]                 message_bytes,
	output logic                       last_chunk
);

	localparam int DEPTH = NUM_SLOTS * MAX_CHUNKS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	crm_pkg::cfg_t                cfg;
	logic                         em_busy;
	logic                         out_free;
	logic                         single_ld;
	crm_pkg::result_t             single_res;
	logic                         start;
	crm_pkg::emit_cmd_t           start_cmd;
	logic [SW-1:0]                start_slot;
	logic [crm_pkg::BYTES-1:0]    ram_be;
	logic [AW-1:0]                ram_waddr;
	logic [crm_pkg::DATA_W-1:0]   ram_wdata;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	logic [crm_pkg::DATA_W-1:0]   ram_rdata;
	crm_pkg::result_t             result;

	crm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crm_ctrl #(
		.NUM_SLOTS  (NUM_SLOTS),
		.MAX_CHUNKS (MAX_CHUNKS),
		.SEQ_BITS   (SEQ_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame_id     (frame_id),
		.frame_data   (frame_data),
		.frame_length (frame_length),
		.em_busy      (em_busy),
		.out_free     (out_free),
		.single_ld    (single_ld),
		.single_res   (single_res),
		.start        (start),
		.start_cmd    (start_cmd),
		.start_slot   (start_slot),
		.ram_be       (ram_be),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	for (genvar b = 0; b < crm_pkg::BYTES; b++) begin : g_lane
		crm_ram #(
			.WIDTH (8),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_be[b]),
			.waddr (ram_waddr),
			.wdata (ram_wdata[8*b +: 8]),
			.re    (ram_re),
			.raddr (ram_raddr),
			.rdata (ram_rdata[8*b +: 8])
		);
	end

	crm_emit #(
		.NUM_SLOTS  (NUM_SLOTS),
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.single_ld    (single_ld),
		.single_res   (single_res),
		.start        (start),
		.start_cmd    (start_cmd),
		.start_slot   (start_slot),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.busy         (em_busy),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign status         = result.status;
	assign message_id     = result.message_id;
	assign message_origin = result.message_origin;
	assign chunk_data     = result.chunk_data;
	assign chunk_bytes    = result.chunk_bytes;
	assign message_bytes  = result.message_bytes;
	assign last_chunk     = result.last_chunk;

endmodule
